@@ hdl/odo_pkg.sv @@
// odo_pkg: types, constants and the arctangent table for the odometry block
// no dependencies; used by every module under hdl
package odo_pkg;

	localparam int CORDIC_STEPS_DEF  = 16;
	localparam int FRACTION_BITS_DEF = 16;

	localparam int ANG_W   = 32;             // binary angle width
	localparam int CW      = 34;             // cordic datapath width
	localparam int SUM_W   = 34;             // sum of two wheel increments
	localparam int PROD_W  = CW + 1 + SUM_W; // serial multiplier product
	localparam int ACC_W   = 56;
	localparam int IDX_W   = 5;              // cordic step index
	localparam int DIV_W   = 48;             // dividend shift register
	localparam int REM_W   = 16;
	localparam int CNT_W   = 6;
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HEADING_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_X      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_Y      = 2'd2;

	localparam logic [REM_W-1:0] HEAD_DIV  = 16'd36000; // centidegrees per turn
	localparam logic [REM_W-1:0] HALF_DIV  = 16'd18000;
	localparam logic [REM_W-1:0] TURN_MOD  = 16'd23296; // 2^32 mod 36000
	localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [CW-1:0] QUARTER     = 34'sd1073741824;
	localparam logic signed [25:0]   START_SCALE = 26'sd503;
	localparam logic [1:0] HEADING_MODE_RST = 2'd1;

	typedef struct packed {
		logic signed [31:0] right_position;
		logic signed [31:0] left_position;
		logic signed [31:0] gyro_rotation;
	} odo_in_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] position_x;
		logic signed [ACC_W-1:0] position_y;
		logic [15:0]             heading_angle;
	} odo_out_t;

	typedef struct packed {
		logic load;
		logic shift;
	} odo_div_ctl_t;

	typedef struct packed {
		logic load;
		logic step;
		logic last;
	} odo_mul_ctl_t;

	function automatic logic [ANG_W-1:0] atan_bam(input logic [IDX_W-1:0] i);
		logic [ANG_W-1:0] v;
		case (i)
			5'd0:  v = 32'h20000000;
			5'd1:  v = 32'h12E4051E;
			5'd2:  v = 32'h09FB385B;
			5'd3:  v = 32'h051111D4;
			5'd4:  v = 32'h028B0D43;
			5'd5:  v = 32'h0145D7E1;
			5'd6:  v = 32'h00A2F61E;
			5'd7:  v = 32'h00517C55;
			5'd8:  v = 32'h0028BE53;
			5'd9:  v = 32'h00145F2F;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2FA;
			5'd15: v = 32'h0000517D;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A30;
			5'd19: v = 32'h00000518;
			5'd20: v = 32'h0000028C;
			5'd21: v = 32'h00000146;
			5'd22: v = 32'h000000A3;
			5'd23: v = 32'h00000051;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

@@ hdl/odo_cdiv.sv @@
// odo_cdiv: bit-serial restoring divider by the constant 36000
// one dividend bit per cycle while shift is set, quotient bits shift in at the bottom; uses odo_pkg
module odo_cdiv (
	input  logic                       clk,
	input  odo_pkg::odo_div_ctl_t      ctl,
	input  logic [odo_pkg::DIV_W-1:0]  load_val,
	output logic [odo_pkg::DIV_W-1:0]  quotient,
	output logic [odo_pkg::REM_W-1:0]  remainder
);
	import odo_pkg::*;

	logic [DIV_W-1:0] sr_q;
	logic [REM_W-1:0] rem_q;
	logic [REM_W:0]   trial;
	logic             qbit;

	always_comb begin
		trial = {rem_q, sr_q[DIV_W-1]};
		qbit  = (trial >= {1'b0, HEAD_DIV});
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			sr_q  <= load_val;
			rem_q <= '0;
		end else if (ctl.shift) begin
			sr_q  <= {sr_q[DIV_W-2:0], qbit};
			rem_q <= qbit ? REM_W'(trial - {1'b0, HEAD_DIV}) : trial[REM_W-1:0];
		end
	end

	assign quotient  = sr_q;
	assign remainder = rem_q;
endmodule

@@ hdl/odo_cordic.sv @@
// odo_cordic: iterative rotation cordic, one step per cycle, cos and sin in Q4.30
// folds the left half-plane onto the right one; uses odo_pkg
module odo_cordic #(
	parameter int STEPS = odo_pkg::CORDIC_STEPS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [odo_pkg::ANG_W-1:0]     angle,
	output logic                          busy,
	output logic signed [odo_pkg::CW-1:0] cos_val,
	output logic signed [odo_pkg::CW-1:0] sin_val
);
	import odo_pkg::*;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STEPS - 1);

	logic                 run_q;
	logic [IDX_W-1:0]     idx_q;
	logic signed [CW-1:0] x_q, y_q, z_q;
	logic                 flip_q;
	logic signed [CW-1:0] z0, xs, ys, at;
	logic                 flip0;

	always_comb begin
		z0    = {{(CW-ANG_W){angle[ANG_W-1]}}, angle};
		flip0 = 1'b0;
		if (z0 > QUARTER) begin
			z0    = z0 - (QUARTER <<< 1);
			flip0 = 1'b1;
		end else if (z0 < -QUARTER) begin
			z0    = z0 + (QUARTER <<< 1);
			flip0 = 1'b1;
		end
		xs = x_q >>> idx_q;
		ys = y_q >>> idx_q;
		at = {{(CW-ANG_W){1'b0}}, atan_bam(idx_q)};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			idx_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			idx_q <= '0;
		end else if (run_q) begin
			idx_q <= idx_q + 1'b1;
			if (idx_q == LAST_IDX) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= CORDIC_GAIN;
			y_q    <= '0;
			z_q    <= z0;
			flip_q <= flip0;
		end else if (run_q) begin
			if (!z_q[CW-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign busy    = run_q;
	assign cos_val = flip_q ? -x_q : x_q;
	assign sin_val = flip_q ? -y_q : y_q;
endmodule

@@ hdl/odo_smul.sv @@
// odo_smul: bit-serial signed multiplier, one multiplier bit per cycle while step is set, lsb first
// the sign bit step subtracts; product leaves as {high, low}; uses odo_pkg
module odo_smul (
	input  logic                              clk,
	input  odo_pkg::odo_mul_ctl_t             ctl,
	input  logic signed [odo_pkg::SUM_W-1:0]  mplier,
	input  logic signed [odo_pkg::CW-1:0]     mcand,
	output logic signed [odo_pkg::PROD_W-1:0] product
);
	import odo_pkg::*;

	logic signed [CW:0]    hi_q;
	logic [SUM_W-1:0]      lo_q;
	logic [SUM_W-1:0]      mp_q;
	logic signed [CW-1:0]  mc_q;
	logic signed [CW:0]    mc_ext, addend, t;

	always_comb begin
		mc_ext = {mc_q[CW-1], mc_q};
		if (!mp_q[0]) begin
			addend = '0;
		end else if (ctl.last) begin
			addend = -mc_ext;
		end else begin
			addend = mc_ext;
		end
		t = hi_q + addend;
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			hi_q <= '0;
			lo_q <= '0;
			mp_q <= mplier;
			mc_q <= mcand;
		end else if (ctl.step) begin
			hi_q <= {t[CW], t[CW:1]};
			lo_q <= {t[0], lo_q[SUM_W-1:1]};
			mp_q <= {1'b0, mp_q[SUM_W-1:1]};
		end
	end

	assign product = {hi_q, lo_q};
endmodule

@@ hdl/differential_drive_odometry.sv @@
// differential_drive_odometry: dead reckoning from wheel encoders and a gyro heading
// uses odo_pkg, odo_cdiv, odo_cordic and odo_smul
//
// channel  dir  handshake                payload
// in       in   in_valid / in_ready      in_data  (odo_in_t)
// out      out  out_valid / out_ready    out_data (odo_out_t)
// cfg      in   cfg_we                   cfg_index, cfg_data
//
// a result is computed by the serial divider (first the gyro modulo, then the angle scaling),
// the cordic (one step a cycle) and the bit-serial multipliers, in that order
// in_ready rises in the same cycle as out_valid, and no new sample is taken before the last is through
// reset clears the encoder history and both positions and sets heading_mode to 1
// a new sample is taken while a result waits; the last cycle holds until out is free
module differential_drive_odometry #(
	parameter int CORDIC_STEPS  = odo_pkg::CORDIC_STEPS_DEF,
	parameter int FRACTION_BITS = odo_pkg::FRACTION_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  odo_pkg::odo_in_t                  in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output odo_pkg::odo_out_t                 out_data,
	input  logic                              cfg_we,
	input  logic [odo_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [odo_pkg::CFG_W-1:0]         cfg_data
);
	import odo_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE = 8'b00000001,
		S_MOD  = 8'b00000010,
		S_FIX  = 8'b00000100,
		S_DIV  = 8'b00001000,
		S_HEAD = 8'b00010000,
		S_ROT  = 8'b00100000,
		S_MUL  = 8'b01000000,
		S_DONE = 8'b10000000
	} state_t;

	localparam logic [CNT_W-1:0] MOD_LAST = CNT_W'(ANG_W - 1);
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_W - 1);
	localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(SUM_W - 1);
	localparam int INC_SH   = 31 - FRACTION_BITS;
	localparam int START_SH = FRACTION_BITS - 8;

	state_t               state_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [31:0]          last_right_q, last_left_q;
	logic [31:0]          dr_q, dl_q;
	logic                 gsign_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [ANG_W-1:0]     bam_q;
	logic [1:0]           mode_q;
	logic [ACC_W-1:0]     acc_x_q, acc_y_q;
	logic                 out_valid_q;
	odo_out_t             out_q;

	logic                 in_xfer, out_free;
	odo_div_ctl_t         div_ctl;
	odo_mul_ctl_t         mul_ctl;
	logic [DIV_W-1:0]     div_load, quotient;
	logic [REM_W-1:0]     remainder, m_w, a_w;
	logic [ANG_W-1:0]     bam_w;
	logic                 rot_busy;
	logic signed [CW-1:0] cos_w, sin_w;
	logic signed [PROD_W-1:0] prod_x, prod_y;
	logic [PROD_W+ACC_W-1:0]  ext_x, ext_y;
	logic [ACC_W-1:0]     inc_x, inc_y, new_x, new_y;
	logic signed [25:0]   start_w;
	logic [ACC_W-1:0]     start_acc;

	assign in_ready = (state_q == S_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// gyro modulo fixup and the negated angle in centidegrees
	always_comb begin
		if (!gsign_q) begin
			m_w = remainder;
		end else if (remainder >= TURN_MOD) begin
			m_w = remainder - TURN_MOD;
		end else begin
			m_w = remainder + (HEAD_DIV - TURN_MOD);
		end
		a_w = (m_w == '0) ? '0 : HEAD_DIV - m_w;
	end

	always_comb begin
		div_ctl.load  = in_xfer || (state_q == S_FIX);
		div_ctl.shift = (state_q == S_MOD) || (state_q == S_DIV);
		div_load      = in_xfer ? {in_data.gyro_rotation, 16'd0}
		                        : {a_w, 32'(HALF_DIV)};
		bam_w         = quotient[ANG_W-1:0] + {mode_q, 30'd0};
		mul_ctl.load  = (state_q == S_ROT) && !rot_busy;
		mul_ctl.step  = (state_q == S_MUL);
		mul_ctl.last  = (cnt_q == MUL_LAST);
	end

	always_comb begin
		ext_x = {{ACC_W{prod_x[PROD_W-1]}}, prod_x};
		ext_y = {{ACC_W{prod_y[PROD_W-1]}}, prod_y};
		inc_x = ext_x[INC_SH +: ACC_W];
		inc_y = ext_y[INC_SH +: ACC_W];
		new_x = acc_x_q + inc_x;
		new_y = acc_y_q + inc_y;
		start_w   = $signed({{10{cfg_data[CFG_W-1]}}, cfg_data}) * START_SCALE;
		start_acc = {{(ACC_W-26){start_w[25]}}, start_w} << START_SH;
	end

	odo_cdiv u_cdiv (
		.clk       (clk),
		.ctl       (div_ctl),
		.load_val  (div_load),
		.quotient  (quotient),
		.remainder (remainder)
	);

	odo_cordic #(
		.STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == S_HEAD),
		.angle   (bam_w),
		.busy    (rot_busy),
		.cos_val (cos_w),
		.sin_val (sin_w)
	);

	odo_smul u_mul_x (
		.clk     (clk),
		.ctl     (mul_ctl),
		.mplier  (sum_q),
		.mcand   (cos_w),
		.product (prod_x)
	);

	odo_smul u_mul_y (
		.clk     (clk),
		.ctl     (mul_ctl),
		.mplier  (sum_q),
		.mcand   (sin_w),
		.product (prod_y)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (in_xfer) begin
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == MOD_LAST) begin
						state_q <= S_FIX;
					end
				end
				S_FIX: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIV_LAST) begin
						state_q <= S_HEAD;
					end
				end
				S_HEAD: begin
					state_q <= S_ROT;
				end
				S_ROT: begin
					cnt_q <= '0;
					if (!rot_busy) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == MUL_LAST) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// encoder history, heading mode, accumulators, output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_right_q <= '0;
			last_left_q  <= '0;
			mode_q       <= HEADING_MODE_RST;
			acc_x_q      <= '0;
			acc_y_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (in_xfer) begin
				last_right_q <= in_data.right_position;
				last_left_q  <= in_data.left_position;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_HEADING_MODE: mode_q  <= cfg_data[1:0];
					REG_START_X:      acc_x_q <= start_acc;
					REG_START_Y:      acc_y_q <= start_acc;
					default: ;
				endcase
			end else if ((state_q == S_DONE) && out_free) begin
				acc_x_q <= new_x;
				acc_y_q <= new_y;
			end
			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			dr_q    <= in_data.right_position - last_right_q;
			dl_q    <= in_data.left_position - last_left_q;
			gsign_q <= in_data.gyro_rotation[31];
		end
		if (state_q == S_MOD) begin
			sum_q <= {{(SUM_W-32){dr_q[31]}}, dr_q} + {{(SUM_W-32){dl_q[31]}}, dl_q};
		end
		if (state_q == S_HEAD) begin
			bam_q <= bam_w;
		end
		if ((state_q == S_DONE) && out_free) begin
			out_q.position_x    <= new_x;
			out_q.position_y    <= new_y;
			out_q.heading_angle <= bam_q[ANG_W-1 -: 16];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_xfer_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q == S_MOD) && !in_ready)
		else $error("input transfer did not start the modulo pass");
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result raised outside the final step");
	a_mul_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL) && (cnt_q == MUL_LAST) |=> (state_q == S_DONE))
		else $error("multiplier pass has the wrong length");
	a_rot_to_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_HEAD) |=> rot_busy)
		else $error("cordic did not start");
`endif
endmodule
